// ===== rtl/hrf_pkg.sv =====
// ----------------------------------------------------------------------------
// hrf_pkg
// Shared types, constants and command structs for the histogram rank filter.
// ----------------------------------------------------------------------------
package hrf_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 16;
   localparam int CHANNELS_DEFAULT    = 3;
   localparam int COARSE_BINS         = 16;
   localparam int FINE_PER_COARSE     = 16;
   localparam int FINE_BINS           = 256;

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_QUERY  = 2'd2,
      REQ_NONE   = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      MODE_MEDIAN = 2'd0,
      MODE_MIN    = 2'd1,
      MODE_MAX    = 2'd2,
      MODE_ALT    = 2'd3
   } mode_code_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPD_READ,
      ST_UPD_WRITE,
      ST_Q_START,
      ST_Q_COARSE_READ,
      ST_Q_COARSE_STEP,
      ST_Q_FINE_READ,
      ST_Q_FINE_STEP,
      ST_Q_NEXT_CH,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic clear_step;   // write zero at clear address, advance
      logic load_req;     // capture request
      logic upd_read;     // read counters for update
      logic upd_write;    // write updated counters
      logic q_init;       // init walk for current channel
      logic coarse_read;  // issue coarse reads at lo/hi
      logic coarse_step;  // take one coarse walk step
      logic fine_init;    // switch walk to fine level
      logic fine_read;    // issue fine reads at lo/hi
      logic fine_step;    // take one fine walk step
      logic next_ch;      // store result, advance channel
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic walk_done;
      logic last_ch;
      logic skip;         // alpha zero or unused code
      req_code_type req;
   } status_type;

endpackage

// ===== rtl/hrf_stream_if.sv =====
// ----------------------------------------------------------------------------
// hrf_stream_if
// Valid/ready channel carrying a generic payload.
// ----------------------------------------------------------------------------
interface hrf_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/hrf_datapath.sv =====
// ----------------------------------------------------------------------------
// hrf_datapath
// Histogram memories, saturating update and two-level rank walk.
// ----------------------------------------------------------------------------
module hrf_datapath #(
   parameter int COUNT_WIDTH = hrf_pkg::COUNT_WIDTH_DEFAULT,
   parameter int CHANNELS    = hrf_pkg::CHANNELS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  hrf_pkg::cmd_type    cmd,
   output hrf_pkg::status_type status,
   input  logic [1:0]          req_code,
   input  logic [7:0]          sample_red,
   input  logic [7:0]          sample_green,
   input  logic [7:0]          sample_blue,
   input  logic [7:0]          sample_alpha,
   input  logic [1:0]          rank_mode,
   output logic [7:0]          result_red,
   output logic [7:0]          result_green,
   output logic [7:0]          result_blue,
   output logic [7:0]          result_alpha
);
   localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int FDEPTH  = hrf_pkg::FINE_BINS * CHANNELS;
   localparam int CDEPTH  = hrf_pkg::COARSE_BINS * CHANNELS;
   localparam int FA_W    = $clog2(FDEPTH);
   localparam int CA_W    = $clog2(CDEPTH);
   localparam int SUM_W   = COUNT_WIDTH + 9;
   localparam logic [COUNT_WIDTH-1:0] CMAX = '1;
   localparam logic [1:0] RES_LAST = 2'd2;

   logic [COUNT_WIDTH-1:0] fine_mem   [FDEPTH];
   logic [COUNT_WIDTH-1:0] coarse_mem [CDEPTH];

   // request capture
   logic [1:0] req_ff;
   logic [7:0] val_ff [3];
   logic [7:0] alpha_ff;
   logic [1:0] mode_ff;

   // clear sweep
   logic [FA_W:0] clr_ff;

   // update pointers
   logic [CH_W-1:0] uch_ff;
   logic [COUNT_WIDTH-1:0] frd_ff, crd_ff;

   // walk state
   logic [1:0]  ch_ff;
   logic [3:0]  lo_ff, hi_ff, coarse_ff;
   logic [SUM_W-1:0] lower_ff, upper_ff;
   logic [COUNT_WIDTH-1:0] rlo_ff, rhi_ff;
   logic        found_ff, cfound_ff;
   logic        end_seen_ff;
   logic [7:0]  res_ff [3];

   logic [7:0]  uval;
   logic [FA_W-1:0] ufa;
   logic [CA_W-1:0] uca;
   logic [FA_W-1:0] fa_lo, fa_hi;
   logic [CA_W-1:0] ca_lo, ca_hi;
   logic [SUM_W-1:0] tot_lo, tot_hi;
   logic [COUNT_WIDTH-1:0] fnew, cnew;
   logic is_min, is_max;

   always_comb begin
      uval = val_ff[uch_ff];
      ufa  = FA_W'({uch_ff, 8'd0}) + FA_W'(uval);
      uca  = CA_W'({uch_ff, 4'd0}) + CA_W'(uval[7:4]);
      ca_lo = CA_W'({ch_ff, 4'd0}) + CA_W'(lo_ff);
      ca_hi = CA_W'({ch_ff, 4'd0}) + CA_W'(hi_ff);
      fa_lo = FA_W'({ch_ff, 8'd0}) + FA_W'({coarse_ff, lo_ff});
      fa_hi = FA_W'({ch_ff, 8'd0}) + FA_W'({coarse_ff, hi_ff});
      tot_lo = lower_ff + SUM_W'(rlo_ff);
      tot_hi = upper_ff + SUM_W'(rhi_ff);
      if (req_ff == hrf_pkg::REQ_INSERT) begin
         fnew = (frd_ff == CMAX) ? frd_ff : frd_ff + 1'b1;
         cnew = (crd_ff == CMAX) ? crd_ff : crd_ff + 1'b1;
      end else begin
         fnew = (frd_ff == '0) ? frd_ff : frd_ff - 1'b1;
         cnew = (crd_ff == '0) ? crd_ff : crd_ff - 1'b1;
      end
      is_min = (mode_ff == hrf_pkg::MODE_MIN);
      is_max = (mode_ff == hrf_pkg::MODE_MAX);
   end

   // memories
   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         fine_mem[clr_ff[FA_W-1:0]] <= '0;
         if (clr_ff < (FA_W+1)'(CDEPTH)) coarse_mem[clr_ff[CA_W-1:0]] <= '0;
      end else if (cmd.upd_write) begin
         fine_mem[ufa]   <= fnew;
         coarse_mem[uca] <= cnew;
      end
      if (cmd.upd_read) begin
         frd_ff <= fine_mem[ufa];
         crd_ff <= coarse_mem[uca];
      end else if (cmd.coarse_read) begin
         rlo_ff <= coarse_mem[ca_lo];
         rhi_ff <= coarse_mem[ca_hi];
      end else if (cmd.fine_read) begin
         rlo_ff <= fine_mem[fa_lo];
         rhi_ff <= fine_mem[fa_hi];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff    <= req_code;
         val_ff[0] <= sample_red;
         val_ff[1] <= sample_green;
         val_ff[2] <= sample_blue;
         alpha_ff  <= sample_alpha;
         mode_ff   <= rank_mode;
         uch_ff    <= '0;
         ch_ff     <= '0;
         // channels without a histogram report zero
         res_ff[0] <= '0;
         res_ff[1] <= '0;
         res_ff[2] <= '0;
      end
      if (cmd.upd_write) uch_ff <= uch_ff + 1'b1;
      if (cmd.q_init) begin
         lo_ff <= '0; hi_ff <= 4'hF;
         lower_ff <= '0; upper_ff <= '0;
         found_ff <= 1'b0; cfound_ff <= 1'b0; coarse_ff <= '0;
      end else if (cmd.coarse_step || cmd.fine_step) begin
         if (is_min || is_max) begin
            // scan from one end; remember first nonzero, hold at the end bin
            if (!found_ff) begin
               if ((is_min ? rlo_ff : rhi_ff) != '0) begin
                  found_ff <= 1'b1;
                  if (cmd.coarse_step) cfound_ff <= 1'b1;
                  if (is_min) hi_ff <= lo_ff; else lo_ff <= hi_ff;
               end else if (is_min) begin
                  if (lo_ff != 4'hF) lo_ff <= lo_ff + 1'b1;
               end else begin
                  if (hi_ff != 4'h0) hi_ff <= hi_ff - 1'b1;
               end
            end
         end else if (tot_lo < tot_hi) begin
            lower_ff <= tot_lo;
            lo_ff    <= lo_ff + 1'b1;
         end else begin
            upper_ff <= tot_hi;
            hi_ff    <= hi_ff - 1'b1;
         end
      end else if (cmd.fine_init) begin
         coarse_ff <= lo_ff;
         found_ff  <= 1'b0;
         lo_ff <= '0; hi_ff <= 4'hF;
      end
      if (cmd.next_ch) begin
         if (alpha_ff == '0) begin
            res_ff[ch_ff] <= val_ff[ch_ff];
         end else if ((is_min || is_max) && !(cfound_ff && found_ff)) begin
            res_ff[ch_ff] <= '0;
         end else begin
            res_ff[ch_ff] <= {coarse_ff, lo_ff};
         end
         ch_ff <= ch_ff + 1'b1;
      end
   end

   // end bin examined: set after a step that examined bin 15 (min) or 0 (max)
   always_ff @(posedge clock) begin
      if (reset || cmd.q_init || cmd.fine_init) begin
         end_seen_ff <= 1'b0;
      end else if ((cmd.coarse_step || cmd.fine_step) &&
                   (is_min ? lo_ff == 4'hF : hi_ff == 4'h0)) begin
         end_seen_ff <= 1'b1;
      end
   end

   always_comb begin
      status.clear_done = (clr_ff == (FA_W+1)'(FDEPTH));
      if (is_min || is_max) begin
         status.walk_done = found_ff || end_seen_ff;
      end else begin
         status.walk_done = (lo_ff == hi_ff);
      end
      status.skip    = (req_ff == hrf_pkg::REQ_NONE) ||
                       (req_ff != hrf_pkg::REQ_QUERY && alpha_ff == '0) ||
                       (req_ff == hrf_pkg::REQ_QUERY && alpha_ff == '0);
      // pass-through covers every result field
      status.last_ch = status.skip ? (ch_ff == RES_LAST) : (ch_ff == 2'(CHANNELS - 1));
      status.req     = hrf_pkg::req_code_type'(req_ff);
   end

   always_comb begin
      result_red   = res_ff[0];
      result_green = res_ff[1];
      result_blue  = res_ff[2];
      result_alpha = alpha_ff;
   end

endmodule

// ===== rtl/hrf_controller.sv =====
// ----------------------------------------------------------------------------
// hrf_controller
// Sequencer for clearing, counter updates and the per-channel rank walk.
// ----------------------------------------------------------------------------
module hrf_controller #(
   parameter int CHANNELS = hrf_pkg::CHANNELS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  hrf_pkg::status_type status,
   output hrf_pkg::cmd_type    cmd
);
   hrf_pkg::state_type state_ff, state_in;
   logic [1:0] uch_ff;
   logic rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hrf_pkg::ST_CLEAR;
         uch_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == hrf_pkg::ST_IDLE) uch_ff <= '0;
         else if (state_ff == hrf_pkg::ST_UPD_WRITE) uch_ff <= uch_ff + 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hrf_pkg::ST_CLEAR:
            if (status.clear_done) state_in = hrf_pkg::ST_IDLE;
         hrf_pkg::ST_IDLE:
            if (req_valid && !rsp_ff) state_in = hrf_pkg::ST_Q_START;
         hrf_pkg::ST_Q_START: begin
            if (status.req == hrf_pkg::REQ_NONE) state_in = hrf_pkg::ST_IDLE;
            else if (status.req == hrf_pkg::REQ_QUERY) state_in =
               status.skip ? hrf_pkg::ST_Q_NEXT_CH : hrf_pkg::ST_Q_COARSE_READ;
            else if (status.skip) state_in = hrf_pkg::ST_IDLE;
            else state_in = hrf_pkg::ST_UPD_READ;
         end
         hrf_pkg::ST_UPD_READ:  state_in = hrf_pkg::ST_UPD_WRITE;
         hrf_pkg::ST_UPD_WRITE:
            state_in = (uch_ff == 2'(CHANNELS - 1)) ? hrf_pkg::ST_IDLE
                                                     : hrf_pkg::ST_UPD_READ;
         hrf_pkg::ST_Q_COARSE_READ:
            state_in = status.walk_done ? hrf_pkg::ST_Q_FINE_READ
                                        : hrf_pkg::ST_Q_COARSE_STEP;
         hrf_pkg::ST_Q_COARSE_STEP: state_in = hrf_pkg::ST_Q_COARSE_READ;
         hrf_pkg::ST_Q_FINE_READ:
            if (!status.walk_done) state_in = hrf_pkg::ST_Q_FINE_STEP;
            else if (status.last_ch) state_in = hrf_pkg::ST_RESPOND;
            else state_in = hrf_pkg::ST_Q_NEXT_CH;
         hrf_pkg::ST_Q_FINE_STEP: state_in = hrf_pkg::ST_Q_FINE_READ;
         hrf_pkg::ST_Q_NEXT_CH:
            if (!status.skip) state_in = hrf_pkg::ST_Q_COARSE_READ;
            else if (status.last_ch) state_in = hrf_pkg::ST_RESPOND;
         hrf_pkg::ST_RESPOND: state_in = hrf_pkg::ST_IDLE;
         default: state_in = hrf_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         hrf_pkg::ST_CLEAR: cmd.clear_step = !status.clear_done;
         hrf_pkg::ST_IDLE: begin
            req_ready    = !rsp_ff;
            cmd.load_req = req_valid && !rsp_ff;
         end
         hrf_pkg::ST_Q_START: cmd.q_init = 1'b1;
         hrf_pkg::ST_UPD_READ: cmd.upd_read = 1'b1;
         hrf_pkg::ST_UPD_WRITE: cmd.upd_write = 1'b1;
         hrf_pkg::ST_Q_COARSE_READ: begin
            cmd.coarse_read = !status.walk_done;
            cmd.fine_init   = status.walk_done;
         end
         hrf_pkg::ST_Q_COARSE_STEP: cmd.coarse_step = 1'b1;
         hrf_pkg::ST_Q_FINE_READ: begin
            cmd.fine_read = !status.walk_done;
            cmd.next_ch   = status.walk_done;
         end
         hrf_pkg::ST_Q_FINE_STEP: cmd.fine_step = 1'b1;
         hrf_pkg::ST_Q_NEXT_CH: begin
            cmd.next_ch = status.skip;
            cmd.q_init  = !status.skip;
         end
         hrf_pkg::ST_RESPOND: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_ff <= 1'b0;
      else if (state_ff == hrf_pkg::ST_RESPOND) rsp_ff <= 1'b1;
      else if (rsp_ready) rsp_ff <= 1'b0;
   end
   assign rsp_valid = rsp_ff;

endmodule

// ===== rtl/histogram_rank_filter_core.sv =====
// ----------------------------------------------------------------------------
// histogram_rank_filter_core
// Per-channel two-level histogram median/min/max filter.
// ----------------------------------------------------------------------------
// After reset the block sweeps its fine and coarse counters to zero, one
// fine entry per cycle, holding req_ready low. One request is handled at
// a time. An insert or remove reads, then does a saturating update and
// write, for each channel in turn on one memory port pair. A query walks
// up to 15 coarse and 15 fine steps per channel for the median and up to
// 16 of each for minimum or maximum, each step a read state then a step
// state; the result is held in an output register until transferred.
module histogram_rank_filter_core #(
   parameter int COUNT_WIDTH = hrf_pkg::COUNT_WIDTH_DEFAULT,
   parameter int CHANNELS    = hrf_pkg::CHANNELS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_type,
   input  logic [7:0] req_sample_red,
   input  logic [7:0] req_sample_green,
   input  logic [7:0] req_sample_blue,
   input  logic [7:0] req_sample_alpha,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_result_red,
   output logic [7:0] rsp_result_green,
   output logic [7:0] rsp_result_blue,
   output logic [7:0] rsp_result_alpha,
   input  logic       csr_write,
   input  logic [1:0] csr_wdata
);
   hrf_pkg::cmd_type    cmd;
   hrf_pkg::status_type status;
   logic [1:0] mode_ff;

   always_ff @(posedge clock) begin
      if (reset) mode_ff <= '0;
      else if (csr_write) mode_ff <= csr_wdata;
   end

   hrf_controller #(.CHANNELS(CHANNELS)) u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .status, .cmd
   );

   hrf_datapath #(.COUNT_WIDTH(COUNT_WIDTH), .CHANNELS(CHANNELS)) u_dp (
      .clock, .reset, .cmd, .status,
      .req_code(req_type),
      .sample_red(req_sample_red), .sample_green(req_sample_green),
      .sample_blue(req_sample_blue), .sample_alpha(req_sample_alpha),
      .rank_mode(mode_ff),
      .result_red(rsp_result_red), .result_green(rsp_result_green),
      .result_blue(rsp_result_blue), .result_alpha(rsp_result_alpha)
   );
endmodule

// ===== rtl/hrf_checker.sv =====
// ----------------------------------------------------------------------------
// hrf_checker
// Port-level checks for the rank filter core.
// ----------------------------------------------------------------------------
module hrf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_result_alpha
);
   a_no_accept_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken with result pending");
   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_alpha))
      else $error("result dropped");
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("ready after transfer");
endmodule

bind histogram_rank_filter_core hrf_checker u_chk (.*);

// ===== dv/hrf_rank_checker.sv =====
// ----------------------------------------------------------------------------
// hrf_rank_checker
// Tracks the per-channel fine and coarse histograms from every request
// transfer and the mode register writes, predicts the rank result of each
// query and compares it field by field with the response transfers.
// ----------------------------------------------------------------------------
module hrf_rank_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [33:0] req_payload,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_payload,
   input  logic        csr_write,
   input  logic [1:0]  csr_wdata,
   output int          pending,
   output int          fail_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import hrf_pkg::*;

   localparam logic [15:0] COUNT_TOP = 16'hFFFF;

   logic [15:0]   fine_hist [3][FINE_BINS];
   logic [15:0]   coarse_hist [3][COARSE_BINS];
   mode_code_type rank_sel;
   logic [31:0]   expected_pixels[$];

   // Two-ended balancing walk, coarse bins first, running sums carried over.
   function automatic logic [7:0] window_median(int ch);
      longint unsigned lower, upper;
      int lo, hi, cbin;
      lower = 0;
      upper = 0;
      lo = 0;
      hi = COARSE_BINS - 1;
      while (lo < hi) begin
         if (lower + coarse_hist[ch][lo] < upper + coarse_hist[ch][hi]) begin
            lower += coarse_hist[ch][lo];
            lo++;
         end else begin
            upper += coarse_hist[ch][hi];
            hi--;
         end
      end
      cbin = lo;
      lo = 0;
      hi = FINE_PER_COARSE - 1;
      while (lo < hi) begin
         if (lower + fine_hist[ch][cbin*16+lo] < upper + fine_hist[ch][cbin*16+hi]) begin
            lower += fine_hist[ch][cbin*16+lo];
            lo++;
         end else begin
            upper += fine_hist[ch][cbin*16+hi];
            hi--;
         end
      end
      return 8'(cbin * 16 + lo);
   endfunction

   function automatic logic [7:0] window_extreme(int ch, bit want_max);
      int c, f, cb, fb;
      for (c = 0; c < COARSE_BINS; c++) begin
         cb = want_max ? COARSE_BINS - 1 - c : c;
         if (coarse_hist[ch][cb] != 0) begin
            for (f = 0; f < FINE_PER_COARSE; f++) begin
               fb = want_max ? FINE_PER_COARSE - 1 - f : f;
               if (fine_hist[ch][cb*16+fb] != 0) return 8'(cb * 16 + fb);
            end
            return 8'd0;
         end
      end
      return 8'd0;
   endfunction

   function automatic logic [7:0] rank_of_channel(int ch);
      case (rank_sel)
         MODE_MIN: return window_extreme(ch, 1'b0);
         MODE_MAX: return window_extreme(ch, 1'b1);
         default:  return window_median(ch);
      endcase
   endfunction

   task automatic apply_request(input logic [33:0] p);
      req_code_type kind;
      logic [7:0] vals [3];
      logic [7:0] alpha;
      logic [31:0] pix;
      int ch;
      kind = req_code_type'(p[33:32]);
      vals[0] = p[31:24];
      vals[1] = p[23:16];
      vals[2] = p[15:8];
      alpha = p[7:0];
      if (kind == REQ_INSERT || kind == REQ_REMOVE) begin
         if (alpha != 0) begin
            for (ch = 0; ch < 3; ch++) begin
               if (kind == REQ_INSERT) begin
                  if (fine_hist[ch][vals[ch]] != COUNT_TOP) fine_hist[ch][vals[ch]]++;
                  if (coarse_hist[ch][vals[ch]>>4] != COUNT_TOP) coarse_hist[ch][vals[ch]>>4]++;
               end else begin
                  if (fine_hist[ch][vals[ch]] != 0) fine_hist[ch][vals[ch]]--;
                  if (coarse_hist[ch][vals[ch]>>4] != 0) coarse_hist[ch][vals[ch]>>4]--;
               end
            end
         end
      end else if (kind == REQ_QUERY) begin
         if (alpha == 0) begin
            pix = p[31:0];
         end else begin
            pix = {rank_of_channel(0), rank_of_channel(1), rank_of_channel(2), alpha};
         end
         expected_pixels.push_back(pix);
      end
   endtask

   always @(posedge clock) begin
      logic [31:0] want;
      if (reset) begin
         foreach (fine_hist[c, i]) fine_hist[c][i] = '0;
         foreach (coarse_hist[c, i]) coarse_hist[c][i] = '0;
         rank_sel = MODE_MEDIAN;
         expected_pixels.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("checker: unexpected response %h", rsp_payload);
            end else begin
               want = expected_pixels.pop_front();
               if (want != rsp_payload) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("checker: mismatch rgba exp %h/%h/%h/%h got %h/%h/%h/%h",
                              want[31:24], want[23:16], want[15:8], want[7:0],
                              rsp_payload[31:24], rsp_payload[23:16],
                              rsp_payload[15:8], rsp_payload[7:0]);
               end
            end
         end
         if (req_valid && req_ready) apply_request(req_payload);
         if (csr_write) rank_sel = mode_code_type'(csr_wdata);
      end
      pending = expected_pixels.size();
   end

   initial begin
      fail_count = 0;
      pending = 0;
   end
endmodule

// ===== dv/tb_histogram_rank_filter_core.sv =====
// ----------------------------------------------------------------------------
// tb_histogram_rank_filter_core
// Drives insert, remove and query requests into the rank filter in directed
// and random phases over all rank modes, with random stalls on both channels
// except in the last phase; the checker predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_histogram_rank_filter_core;
   timeunit 1ns;
   timeprecision 1ps;
   import hrf_pkg::*;

   localparam int STALL_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [1:0] csr_wdata = '0;
   bit   idle_on = 1'b1;
   int   pending, fail_count, quiet_cycles;
   logic [31:0] pixel_pool[$];

   hrf_stream_if #(.payload_type(logic [33:0])) req_if ();
   hrf_stream_if #(.payload_type(logic [31:0])) rsp_if ();

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   histogram_rank_filter_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_if.valid),
      .req_ready        (req_if.ready),
      .req_type         (req_if.payload[33:32]),
      .req_sample_red   (req_if.payload[31:24]),
      .req_sample_green (req_if.payload[23:16]),
      .req_sample_blue  (req_if.payload[15:8]),
      .req_sample_alpha (req_if.payload[7:0]),
      .rsp_valid        (rsp_if.valid),
      .rsp_ready        (rsp_if.ready),
      .rsp_result_red   (rsp_if.payload[31:24]),
      .rsp_result_green (rsp_if.payload[23:16]),
      .rsp_result_blue  (rsp_if.payload[15:8]),
      .rsp_result_alpha (rsp_if.payload[7:0]),
      .csr_write        (csr_write),
      .csr_wdata        (csr_wdata)
   );

   hrf_rank_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_ready   (req_if.ready),
      .req_payload (req_if.payload),
      .rsp_valid   (rsp_if.valid),
      .rsp_ready   (rsp_if.ready),
      .rsp_payload (rsp_if.payload),
      .csr_write   (csr_write),
      .csr_wdata   (csr_wdata),
      .pending     (pending),
      .fail_count  (fail_count)
   );

   initial begin
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
   end

   // Response side: stall in random bursts while idling is enabled.
   always @(posedge clock) begin
      int gap;
      if (!reset && idle_on && $urandom_range(0, 9) == 0) begin
         gap = $urandom_range(1, 16);
         rsp_if.ready <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      rsp_if.ready <= 1'b1;
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb_histogram_rank_filter_core: FAIL");
         $finish;
      end
   end

   task automatic send_request(input req_code_type kind, input logic [31:0] pix);
      int gap;
      if (idle_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 16);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= {kind, pix};
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Hold off until all responses are in and the block has settled, then write.
   task automatic write_rank_mode(input mode_code_type m);
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      csr_write <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   function automatic logic [31:0] random_pixel(bit clustered);
      logic [7:0] base;
      logic [31:0] pix;
      base = 8'($urandom_range(0, 255));
      pix = $urandom;
      if (clustered) begin
         pix[31:24] = base ^ 8'($urandom_range(0, 7));
         pix[23:16] = base + 8'($urandom_range(0, 20));
         pix[15:8]  = ~base ^ 8'($urandom_range(0, 3));
      end
      if (pix[7:0] == 0) pix[7:0] = 8'($urandom_range(1, 255));
      return pix;
   endfunction

   task automatic random_item();
      int pick, idx;
      logic [31:0] pix;
      pick = $urandom_range(0, 99);
      if (pixel_pool.size() > 40 && pick < 45) pick = 50;
      if (pick < 45) begin
         pix = random_pixel($urandom_range(0, 1));
         if ($urandom_range(0, 19) == 0) pix[7:0] = 8'd0;
         else pixel_pool.push_back(pix);
         send_request(REQ_INSERT, pix);
      end else if (pick < 70 && pixel_pool.size() != 0) begin
         idx = $urandom_range(0, pixel_pool.size() - 1);
         pix = pixel_pool[idx];
         pixel_pool.delete(idx);
         send_request(REQ_REMOVE, pix);
      end else if (pick < 90) begin
         pix = $urandom;
         if ($urandom_range(0, 9) == 0) pix[7:0] = 8'd0;
         send_request(REQ_QUERY, pix);
      end else if (pick < 96) begin
         send_request(REQ_REMOVE, $urandom);
      end else begin
         send_request(REQ_NONE, $urandom);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty window, skipped pixels, extremes, unused codes.
      send_request(REQ_QUERY,  32'h12_34_56_78);
      send_request(REQ_QUERY,  32'hAB_CD_EF_00);
      send_request(REQ_REMOVE, 32'h00_FF_80_01);
      send_request(REQ_QUERY,  32'hFF_FF_FF_FF);
      send_request(REQ_INSERT, 32'hFF_FF_FF_00);
      send_request(REQ_NONE,   32'h55_AA_55_AA);
      send_request(REQ_INSERT, 32'h00_FF_0F_FF);
      send_request(REQ_INSERT, 32'hFF_00_F0_01);
      send_request(REQ_QUERY,  32'h00_00_00_80);
      send_request(REQ_INSERT, 32'h10_1F_7F_33);
      send_request(REQ_QUERY,  32'hFF_FF_FF_7F);
      for (int m = MODE_MIN; m <= MODE_ALT; m++) begin
         write_rank_mode(mode_code_type'(m));
         send_request(REQ_QUERY, 32'hA5_5A_C3_01);
         send_request(REQ_QUERY, 32'hA5_5A_C3_00);
      end
      // Leave a fine count with no coarse count behind it.
      send_request(REQ_REMOVE, 32'h01_10_70_01);
      send_request(REQ_QUERY,  32'h00_00_00_FE);
      write_rank_mode(MODE_MEDIAN);

      for (int phase = 0; phase < 8; phase++) begin
         if (phase == 7) idle_on = 1'b0;
         if (phase == 4) begin
            while (pixel_pool.size() != 0) send_request(REQ_REMOVE, pixel_pool.pop_front());
            send_request(REQ_QUERY, 32'h01_02_03_04);
         end
         repeat (155) random_item();
         write_rank_mode(mode_code_type'((phase + 1) % 4));
      end

      req_if.valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (fail_count == 0)
         $display("tb_histogram_rank_filter_core: PASS");
      else
         $display("tb_histogram_rank_filter_core: FAIL");
      $finish;
   end
endmodule

// ===== files.f =====
rtl/hrf_pkg.sv
rtl/hrf_stream_if.sv
rtl/hrf_datapath.sv
rtl/hrf_controller.sv
rtl/histogram_rank_filter_core.sv
rtl/hrf_checker.sv
dv/hrf_rank_checker.sv
dv/tb_histogram_rank_filter_core.sv
